>>> hdl/first_fit_heap_allocator_defines.svh
// Assertion macros used by the allocator controller RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FFHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffha: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffha: assertion failed");

`endif

>>> hdl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int SIZE_W = 13;
    localparam int OFFS_W = 12;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_REST,
        WR_CUR,
        WR_LINK_REST,
        WR_LINK_NEXT,
        WR_LINK_HDR,
        WR_HDR
    } t_wr;

    typedef struct packed {
        logic start;
        logic rd;
        logic step;
        t_wr  wr;
        logic done;
        logic ok;
        logic give;
    } t_cmd;

    typedef struct packed {
        logic at_end;
        logic limit;
        logic fits;
        logic split;
        logic reached;
        logic free_bad;
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

>>> hdl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/ffha_datapath.sv
// ----------------------------------------------------------------------------
// ffha_datapath
// Header stores, chain walk registers, split arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_datapath #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ffha_pkg::t_cmd                i_cmd,
    output ffha_pkg::t_status                  o_status,
    input  wire logic [ffha_pkg::SIZE_W-1:0]   i_request_size,
    input  wire logic [ffha_pkg::OFFS_W-1:0]   i_block_offset,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_success,
    output logic      [ffha_pkg::OFFS_W-1:0]   o_data_offset
);

    localparam int SW = ffha_pkg::SIZE_W;
    localparam int OW = ffha_pkg::OFFS_W;
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int PW = AW + 1;
    localparam int EW = ((PW > SW) ? PW : SW) + 2;
    localparam int WALK_LIMIT = HEAP_BYTES / HEADER_BYTES;
    localparam int VW = $clog2(WALK_LIMIT + 1);

    localparam logic [PW-1:0] CHAIN_END = PW'(HEAP_BYTES);
    localparam logic [EW-1:0] HEAP_E    = EW'(HEAP_BYTES);
    localparam logic [EW-1:0] HDR_E     = EW'(HEADER_BYTES);
    localparam logic [VW-1:0] LIMIT_V   = VW'(WALK_LIMIT);
    localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);

    logic [PW-1:0] r_head;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] r_prev;
    logic [PW-1:0] r_hdr;
    logic [SW-1:0] r_want;
    logic [VW-1:0] r_visits;
    logic          r_out_valid;
    logic          r_success;
    logic [OW-1:0] r_data_offset;

    logic [SW-1:0] w_size_rd;
    logic [PW-1:0] w_next_rd;

    logic [EW-1:0] w_rest;
    logic [EW-1:0] w_need;
    logic [EW-1:0] w_left;
    logic [EW-1:0] w_free_hdr;
    logic [EW-1:0] w_data_offs;
    logic [PW-1:0] w_link_tgt;

    logic          w_size_we;
    logic [AW-1:0] w_size_waddr;
    logic [SW-1:0] w_size_wdata;
    logic          w_next_we;
    logic [AW-1:0] w_next_waddr;
    logic [PW-1:0] w_next_wdata;
    logic          w_head_we;

    ffha_ram #(.WIDTH(SW), .DEPTH(HEAP_BYTES)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_size_we),
        .i_waddr (w_size_waddr),
        .i_wdata (w_size_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (w_size_rd)
    );

    ffha_ram #(.WIDTH(PW), .DEPTH(HEAP_BYTES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (w_next_rd)
    );

    assign w_rest      = EW'(r_cur) + HDR_E + EW'(r_want);
    assign w_need      = EW'(r_want) + HDR_E;
    assign w_left      = EW'(w_size_rd) - w_need;
    assign w_free_hdr  = EW'(i_block_offset) - HDR_E;
    assign w_data_offs = EW'(r_cur) + HDR_E;

    always_comb begin
        o_status.at_end   = (r_cur >= CHAIN_END);
        o_status.limit    = (r_visits >= LIMIT_V);
        o_status.fits     = (w_size_rd >= r_want);
        o_status.split    = (EW'(w_size_rd) >= w_need) && (w_rest < HEAP_E);
        o_status.reached  = (r_cur >= r_hdr);
        o_status.free_bad = (EW'(i_block_offset) < HDR_E) || (w_free_hdr >= HEAP_E);
        o_status.out_full = r_out_valid;
    end

    always_comb begin
        case (i_cmd.wr)
            ffha_pkg::WR_LINK_REST: w_link_tgt = w_rest[PW-1:0];
            ffha_pkg::WR_LINK_NEXT: w_link_tgt = w_next_rd;
            default:                w_link_tgt = r_hdr;
        endcase
    end

    always_comb begin
        w_size_we    = 1'b0;
        w_size_waddr = r_cur[AW-1:0];
        w_size_wdata = r_want;
        w_next_we    = 1'b0;
        w_next_waddr = r_cur[AW-1:0];
        w_next_wdata = CHAIN_END;
        w_head_we    = 1'b0;
        case (i_cmd.wr)
            ffha_pkg::WR_INIT: begin
                w_size_we    = 1'b1;
                w_size_waddr = '0;
                w_size_wdata = INIT_SIZE;
                w_next_we    = 1'b1;
                w_next_waddr = '0;
            end
            ffha_pkg::WR_REST: begin
                w_size_we    = 1'b1;
                w_size_waddr = w_rest[AW-1:0];
                w_size_wdata = w_left[SW-1:0];
                w_next_we    = 1'b1;
                w_next_waddr = w_rest[AW-1:0];
                w_next_wdata = w_next_rd;
            end
            ffha_pkg::WR_CUR: begin
                w_size_we = 1'b1;
                w_next_we = 1'b1;
            end
            ffha_pkg::WR_LINK_REST, ffha_pkg::WR_LINK_NEXT, ffha_pkg::WR_LINK_HDR: begin
                w_next_waddr = r_prev[AW-1:0];
                w_next_wdata = w_link_tgt;
                if (r_prev >= CHAIN_END) begin
                    w_head_we = 1'b1;
                end else begin
                    w_next_we = 1'b1;
                end
            end
            ffha_pkg::WR_HDR: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_hdr[AW-1:0];
                w_next_wdata = r_cur;
            end
            default: begin
                w_size_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_head_we) begin
                r_head <= w_link_tgt;
            end
            if (i_cmd.done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur    <= r_head;
            r_prev   <= CHAIN_END;
            r_visits <= '0;
            r_want   <= i_request_size;
            r_hdr    <= w_free_hdr[PW-1:0];
        end else if (i_cmd.step) begin
            r_prev   <= r_cur;
            r_cur    <= w_next_rd;
            r_visits <= r_visits + VW'(1);
        end
        if (i_cmd.done) begin
            r_success     <= i_cmd.ok;
            r_data_offset <= i_cmd.give ? w_data_offs[OW-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_data_offset = r_data_offset;

endmodule

`default_nettype wire

>>> hdl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for store init, allocate walk/split and free walk/insert.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_action,
    input  wire ffha_pkg::t_status i_status,
    output ffha_pkg::t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_CHECK,
        S_A_EVAL,
        S_A_CUR,
        S_A_LINK,
        S_F_CHECK,
        S_F_EVAL,
        S_F_HDR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ok;
    logic   n_ok;
    logic   r_give;
    logic   n_give;

    always_comb begin
        n_state     = r_state;
        n_ok        = r_ok;
        n_give      = r_give;
        o_cmd.start = 1'b0;
        o_cmd.rd    = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.wr    = ffha_pkg::WR_NONE;
        o_cmd.done  = 1'b0;
        o_cmd.ok    = r_ok;
        o_cmd.give  = r_give;
        case (r_state)
            S_INIT: begin
                o_cmd.wr = ffha_pkg::WR_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ffha_pkg::ACT_ALLOC) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_A_CHECK;
                    end else if (i_status.free_bad) begin
                        n_ok    = 1'b0;
                        n_give  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_F_CHECK;
                    end
                end
            end
            S_A_CHECK: begin
                if (i_status.at_end || i_status.limit) begin
                    n_ok    = 1'b0;
                    n_give  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_A_EVAL;
                end
            end
            S_A_EVAL: begin
                if (!i_status.fits) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_A_CHECK;
                end else if (i_status.split) begin
                    o_cmd.wr = ffha_pkg::WR_REST;
                    n_state  = S_A_CUR;
                end else begin
                    o_cmd.wr = ffha_pkg::WR_LINK_NEXT;
                    n_ok     = 1'b1;
                    n_give   = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_A_CUR: begin
                o_cmd.wr = ffha_pkg::WR_CUR;
                n_state  = S_A_LINK;
            end
            S_A_LINK: begin
                o_cmd.wr = ffha_pkg::WR_LINK_REST;
                n_ok     = 1'b1;
                n_give   = 1'b1;
                n_state  = S_DONE;
            end
            S_F_CHECK: begin
                if (i_status.at_end || i_status.reached) begin
                    o_cmd.wr = ffha_pkg::WR_LINK_HDR;
                    n_state  = S_F_HDR;
                end else if (i_status.limit) begin
                    n_ok    = 1'b0;
                    n_give  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_F_EVAL;
                end
            end
            S_F_EVAL: begin
                o_cmd.step = 1'b1;
                n_state    = S_F_CHECK;
            end
            S_F_HDR: begin
                o_cmd.wr = ffha_pkg::WR_HDR;
                n_ok     = 1'b1;
                n_give   = 1'b0;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_full) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ok    <= 1'b0;
            r_give  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
            r_give  <= n_give;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `FFHA_ASSERT_IMPL(a_done_has_room, i_clk, i_rst_n, o_cmd.done, !i_status.out_full)
    `FFHA_ASSERT_IMPL(a_read_in_chain, i_clk, i_rst_n, o_cmd.rd, !i_status.at_end && !i_status.limit)
    `FFHA_ASSERT_NEXT(a_busy_after_word, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `FFHA_ASSERT_IMPL(a_split_on_fit, i_clk, i_rst_n, o_cmd.wr == ffha_pkg::WR_REST, i_status.fits && i_status.split)

endmodule

`default_nettype wire

>>> hdl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-chain heap allocator with address-ordered insert on free.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (i_in_valid/o_in_ready): i_action 0 allocates i_request_size
//   bytes, 1 frees the block whose data offset is i_block_offset.
//   Output word (o_out_valid/i_out_ready): o_success and o_data_offset.
//   Each request walks the free chain, with one header store read and one
//   compare for each visited header. An allocate that fits may split the
//   block; the headers visited (for free, those passed) are at most
//   HEAP_BYTES / HEADER_BYTES (256 by default). A free with a bad offset
//   skips the walk and goes straight to its result.
//   One word is in work at a time; a new one is accepted once the previous
//   result sits in the output register.
//   Reset: one cycle after reset is spent writing the single whole-heap
//   free header at offset 0; o_in_ready stays low during it.
//   Stall: a result waits in the output register while i_out_ready is low;
//   one more word may be accepted and worked up to its result, then held.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic [ffha_pkg::SIZE_W-1:0]   i_request_size,
    input  wire logic [ffha_pkg::OFFS_W-1:0]   i_block_offset,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_success,
    output logic      [ffha_pkg::OFFS_W-1:0]   o_data_offset
);

    ffha_pkg::t_cmd    w_cmd;
    ffha_pkg::t_status w_status;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ffha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_request_size (i_request_size),
        .i_block_offset (i_block_offset),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_success      (o_success),
        .o_data_offset  (o_data_offset)
    );

endmodule

`default_nettype wire
